[rtl/text_token_lexer_assert.svh]
// ---------------------------------------------------------------------------
// text_token_lexer assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_TOKEN_LEXER_ASSERT_SVH
`define TEXT_TOKEN_LEXER_ASSERT_SVH

`ifndef SYNTH
`define TTL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define TTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TTL_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define TTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/tlx_pkg.sv]
// ---------------------------------------------------------------------------
// tlx_pkg
// Shared types, codes and character classes of the text token lexer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlx_pkg;

    localparam int LEN_WIDTH_DEF = 11;
    localparam int CAP_LIMIT     = 1024;
    localparam int CFG_RESET     = 256;
    localparam int LINE_W        = 20;
    localparam int RES_MAX       = 3;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_STR,
        MODE_STR_AFTER,
        MODE_DISCARD,
        MODE_COMMENT,
        MODE_COMMENT_AFTER
    } mode_t;

    typedef enum logic [2:0] {
        CLS_OP      = 3'd0,
        CLS_STR     = 3'd1,
        CLS_INT     = 3'd2,
        CLS_IDENT   = 3'd3,
        CLS_ERR     = 3'd4,
        CLS_STR_BAD = 3'd5,
        CLS_END     = 3'd6
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [7:0]        ch;
        logic              valid;
        logic              tend;
        logic [LINE_W-1:0] line;
    } res_t;

    // Results caused by one input byte, oldest in slot 0
    typedef struct packed {
        logic [1:0]              count;
        res_t [RES_MAX-1:0]      res;
    } bundle_t;

    function automatic res_t make_res(cls_t c, logic [7:0] ch, logic v, logic e,
                                      logic [LINE_W-1:0] ln);
        res_t r;
        r.cls   = c;
        r.ch    = ch;
        r.valid = v;
        r.tend  = e;
        r.line  = ln;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h00);
    endfunction

    function automatic logic is_operator(logic [7:0] b);
        logic hit;
        case (b)
            CH_AT, 8'h2C, 8'h21, 8'h26, 8'h2A, 8'h24, 8'h2E, 8'h3D, 8'h3A,
            8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7B, 8'h7D, CH_BSLASH: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

[rtl/tlx_front.sv]
// ---------------------------------------------------------------------------
// tlx_front
// Lexer state machine: classifies one byte per beat into a result bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlx_front #(
    parameter int LEN_WIDTH = tlx_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 kind,
    input  wire logic [7:0]           text_byte,
    input  wire logic [LEN_WIDTH-1:0] max_len,
    output tlx_pkg::bundle_t          q_wdata,
    output logic                      q_push
);

    localparam int LW1 = LEN_WIDTH + 1;
    localparam int CAP_INT = (tlx_pkg::CAP_LIMIT < (1 << LEN_WIDTH)) ?
                             tlx_pkg::CAP_LIMIT : (1 << LEN_WIDTH) - 1;
    localparam logic [LEN_WIDTH-1:0] CapLim = LEN_WIDTH'(CAP_INT);

    tlx_pkg::mode_t                mode_reg, mode_next;
    logic [tlx_pkg::LINE_W-1:0]    line_reg, line_next;
    logic [LEN_WIDTH-1:0]          tlen_reg, tlen_next;
    logic                          join_reg, join_next;
    logic                          esc_reg, esc_next;
    logic                          slash_reg, slash_next;
    logic [LEN_WIDTH-1:0]          cap;

    assign cap = (max_len > CapLim) ? CapLim : max_len;

    always_comb
    begin
        tlx_pkg::res_t [tlx_pkg::RES_MAX-1:0] r;
        logic [1:0]                 n;
        logic                       do_idle;
        logic                       skip;
        logic                       roomy;
        logic [7:0]                 b;

        b          = text_byte;
        r          = '0;
        n          = 2'd0;
        do_idle    = 1'b0;
        skip       = 1'b0;
        mode_next  = mode_reg;
        line_next  = line_reg;
        tlen_next  = tlen_reg;
        join_next  = join_reg;
        esc_next   = esc_reg;
        slash_next = slash_reg;
        roomy      = (LW1'(tlen_reg) + LW1'(1)) < LW1'(cap);

        if (kind)
        begin
            case (mode_reg)
                tlx_pkg::MODE_IDENT:
                begin
                    r[n] = tlx_pkg::make_res(tlx_pkg::CLS_IDENT, 8'h00, 1'b0, 1'b1, line_next);
                    n = n + 2'd1;
                end
                tlx_pkg::MODE_INT:
                begin
                    r[n] = tlx_pkg::make_res(tlx_pkg::CLS_INT, 8'h00, 1'b0, 1'b1, line_next);
                    n = n + 2'd1;
                end
                tlx_pkg::MODE_STR:
                begin
                    r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR_BAD, 8'h00, 1'b0, 1'b1,
                                             line_next);
                    n = n + 2'd1;
                end
                tlx_pkg::MODE_STR_AFTER:
                begin
                    r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR, 8'h00, 1'b0, 1'b1, line_next);
                    n = n + 2'd1;
                end
                tlx_pkg::MODE_COMMENT:
                begin
                    if (line_next != tlx_pkg::LINE_MAX)
                        line_next = line_next + 1'b1;
                end
                tlx_pkg::MODE_COMMENT_AFTER:
                begin
                    if (line_next != tlx_pkg::LINE_MAX)
                        line_next = line_next + 1'b1;
                    r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR, 8'h00, 1'b0, 1'b1, line_next);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            if (slash_reg)
            begin
                r[n] = tlx_pkg::make_res(tlx_pkg::CLS_ERR, tlx_pkg::CH_SLASH, 1'b0, 1'b1,
                                         line_next);
                n = n + 2'd1;
            end
            r[n] = tlx_pkg::make_res(tlx_pkg::CLS_END, 8'h00, 1'b0, 1'b1, line_next);
            n = n + 2'd1;
            mode_next  = tlx_pkg::MODE_IDLE;
            tlen_next  = '0;
            join_next  = 1'b0;
            esc_next   = 1'b0;
            slash_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                tlx_pkg::MODE_IDENT:
                begin
                    if (tlx_pkg::is_alpha(b) || tlx_pkg::is_digit(b) || b == tlx_pkg::CH_UNDER)
                    begin
                        if (roomy)
                        begin
                            r[n] = tlx_pkg::make_res(tlx_pkg::CLS_IDENT, b, 1'b1, 1'b0,
                                                     line_next);
                            n = n + 2'd1;
                            tlen_next = tlen_next + 1'b1;
                        end
                    end
                    else
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_IDENT, 8'h00, 1'b0, 1'b1,
                                                 line_next);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                tlx_pkg::MODE_INT:
                begin
                    if (tlx_pkg::is_digit(b))
                    begin
                        if (roomy)
                        begin
                            r[n] = tlx_pkg::make_res(tlx_pkg::CLS_INT, b, 1'b1, 1'b0, line_next);
                            n = n + 2'd1;
                            tlen_next = tlen_next + 1'b1;
                        end
                    end
                    else if (b == tlx_pkg::CH_MINUS || tlx_pkg::is_alpha(b) ||
                             b == tlx_pkg::CH_UNDER)
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_ERR, b, 1'b0, 1'b1, line_next);
                        n = n + 2'd1;
                        mode_next = tlx_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_INT, 8'h00, 1'b0, 1'b1,
                                                 line_next);
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                tlx_pkg::MODE_STR:
                begin
                    if (b == tlx_pkg::CH_QUOTE)
                    begin
                        esc_next  = 1'b0;
                        join_next = 1'b0;
                        mode_next = tlx_pkg::MODE_STR_AFTER;
                    end
                    else if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR,
                                                 (b == tlx_pkg::CH_N) ? tlx_pkg::CH_NL : b,
                                                 1'b1, 1'b0, line_next);
                        n = n + 2'd1;
                        tlen_next = tlen_next + 1'b1;
                    end
                    else if (b == tlx_pkg::CH_NL || !roomy)
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR_BAD, b, 1'b0, 1'b1,
                                                 line_next);
                        n = n + 2'd1;
                        mode_next = tlx_pkg::MODE_DISCARD;
                    end
                    else if (b == tlx_pkg::CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR, b, 1'b1, 1'b0, line_next);
                        n = n + 2'd1;
                        tlen_next = tlen_next + 1'b1;
                    end
                end
                tlx_pkg::MODE_STR_AFTER:
                begin
                    if (slash_reg)
                    begin
                        if (b == tlx_pkg::CH_SLASH)
                        begin
                            slash_next = 1'b0;
                            mode_next  = tlx_pkg::MODE_COMMENT_AFTER;
                        end
                        else
                        begin
                            // close the string; the idle path then flags the lone slash
                            r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR, 8'h00, 1'b0, 1'b1,
                                                     line_next);
                            n = n + 2'd1;
                            join_next = 1'b0;
                            do_idle   = 1'b1;
                        end
                    end
                    else if (tlx_pkg::is_space(b))
                    begin
                    end
                    else if (b == tlx_pkg::CH_PLUS)
                    begin
                        join_next = 1'b1;
                    end
                    else if (b == tlx_pkg::CH_NL)
                    begin
                        if (line_next != tlx_pkg::LINE_MAX)
                            line_next = line_next + 1'b1;
                    end
                    else if (b == tlx_pkg::CH_SLASH)
                    begin
                        slash_next = 1'b1;
                    end
                    else if (b == tlx_pkg::CH_QUOTE && join_reg)
                    begin
                        join_next = 1'b0;
                        esc_next  = 1'b0;
                        mode_next = tlx_pkg::MODE_STR;
                    end
                    else
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_STR, 8'h00, 1'b0, 1'b1,
                                                 line_next);
                        n = n + 2'd1;
                        join_next = 1'b0;
                        do_idle   = 1'b1;
                    end
                end
                tlx_pkg::MODE_DISCARD:
                begin
                    if (b == tlx_pkg::CH_QUOTE)
                    begin
                        mode_next = tlx_pkg::MODE_STR;
                        tlen_next = '0;
                        esc_next  = 1'b0;
                    end
                end
                tlx_pkg::MODE_COMMENT, tlx_pkg::MODE_COMMENT_AFTER:
                begin
                    if (b == tlx_pkg::CH_NL)
                    begin
                        if (line_next != tlx_pkg::LINE_MAX)
                            line_next = line_next + 1'b1;
                        mode_next = (mode_reg == tlx_pkg::MODE_COMMENT) ?
                                    tlx_pkg::MODE_IDLE : tlx_pkg::MODE_STR_AFTER;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                mode_next = tlx_pkg::MODE_IDLE;
                if (slash_next)
                begin
                    slash_next = 1'b0;
                    if (b == tlx_pkg::CH_SLASH)
                    begin
                        mode_next = tlx_pkg::MODE_COMMENT;
                        skip      = 1'b1;
                    end
                    else
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_ERR, tlx_pkg::CH_SLASH, 1'b0,
                                                 1'b1, line_next);
                        n = n + 2'd1;
                    end
                end
                if (!skip && !(tlx_pkg::is_space(b) || b == tlx_pkg::CH_PLUS))
                begin
                    if (b == tlx_pkg::CH_NL)
                    begin
                        if (line_next != tlx_pkg::LINE_MAX)
                            line_next = line_next + 1'b1;
                    end
                    else if (b == tlx_pkg::CH_SLASH)
                    begin
                        slash_next = 1'b1;
                    end
                    else if (tlx_pkg::is_operator(b))
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_OP, b, 1'b1, 1'b1, line_next);
                        n = n + 2'd1;
                    end
                    else if (b == tlx_pkg::CH_QUOTE)
                    begin
                        mode_next = tlx_pkg::MODE_STR;
                        tlen_next = '0;
                        esc_next  = 1'b0;
                    end
                    else if (tlx_pkg::is_digit(b) || b == tlx_pkg::CH_MINUS)
                    begin
                        mode_next = tlx_pkg::MODE_INT;
                        tlen_next = '0;
                        if (LW1'(cap) > LW1'(1))
                        begin
                            r[n] = tlx_pkg::make_res(tlx_pkg::CLS_INT, b, 1'b1, 1'b0,
                                                     line_next);
                            n = n + 2'd1;
                            tlen_next = LEN_WIDTH'(1);
                        end
                    end
                    else if (tlx_pkg::is_alpha(b) || b == tlx_pkg::CH_UNDER)
                    begin
                        mode_next = tlx_pkg::MODE_IDENT;
                        tlen_next = '0;
                        if (LW1'(cap) > LW1'(1))
                        begin
                            r[n] = tlx_pkg::make_res(tlx_pkg::CLS_IDENT, b, 1'b1, 1'b0,
                                                     line_next);
                            n = n + 2'd1;
                            tlen_next = LEN_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        r[n] = tlx_pkg::make_res(tlx_pkg::CLS_ERR, b, 1'b0, 1'b1, line_next);
                        n = n + 2'd1;
                    end
                end
            end
        end

        q_wdata.count = n;
        q_wdata.res   = r;
        q_push        = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tlx_pkg::MODE_IDLE;
            line_reg  <= tlx_pkg::LINE_W'(1);
            tlen_reg  <= '0;
            join_reg  <= 1'b0;
            esc_reg   <= 1'b0;
            slash_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            tlen_reg  <= tlen_next;
            join_reg  <= join_next;
            esc_reg   <= esc_next;
            slash_reg <= slash_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tlx_queue.sv]
// ---------------------------------------------------------------------------
// tlx_queue
// Small bundle queue between the lexer front and the result back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlx_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire tlx_pkg::bundle_t wr_data,
    output logic                  q_full,
    output logic                  rd_valid,
    output tlx_pkg::bundle_t      rd_data,
    input  wire logic             rd_en
);

    localparam int DEPTH = tlx_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    tlx_pkg::bundle_t  mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign q_full   = (count_reg == (AW + 1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tlx_back.sv]
// ---------------------------------------------------------------------------
// tlx_back
// Unpacks bundles into single results behind an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlx_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_valid,
    input  wire tlx_pkg::bundle_t rd_data,
    output logic                  rd_en,
    input  wire logic             pop,
    output logic                  out_valid,
    output tlx_pkg::res_t         out_res
);

    logic               valid_reg, valid_next;
    logic [1:0]         idx_reg, idx_next;
    tlx_pkg::res_t      res_reg;
    logic               load;
    logic               last;

    // take the next result whenever the output slot is free or being drained
    assign load  = !valid_reg || pop;
    assign last  = (idx_reg + 2'd1) == rd_data.count;
    assign rd_en = load && rd_valid && last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = rd_valid;
            if (rd_valid)
                idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && rd_valid)
            res_reg <= rd_data.res[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[rtl/text_token_lexer.sv]
// ---------------------------------------------------------------------------
// text_token_lexer
// Streaming tokenizer: bytes in, token characters with class and end out.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          kind, text_byte
//  result    empty / pop          token_class, out_char, char_valid,
//                                 token_end, line_number
//  config    cfg_we               cfg_wdata (max_token_len)
//
//  The front takes one byte per cycle while full is low and turns it into
//  zero to three results in the same cycle; these wait as one bundle in a
//  four-deep queue. The back end delivers one result per cycle while pop is
//  held, unpacking each bundle in order; full rises only when the queue fills.
//  A queued bundle's results enter the output register when it is empty or popped.
//  Reset clears the control registers at once: line count one, max_token_len 256.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_token_lexer_assert.svh"

module text_token_lexer #(
    parameter int LEN_WIDTH = tlx_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          kind,
    input  wire logic [7:0]                    text_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [2:0]                         token_class,
    output logic [7:0]                         out_char,
    output logic                               char_valid,
    output logic                               token_end,
    output logic [tlx_pkg::LINE_W-1:0]         line_number,
    input  wire logic                          cfg_we,
    input  wire logic [LEN_WIDTH-1:0]          cfg_wdata
);

    logic [LEN_WIDTH-1:0]  max_len_reg;
    logic                  accept;
    logic                  q_push;
    logic                  q_full;
    logic                  q_rd_valid;
    logic                  q_rd_en;
    tlx_pkg::bundle_t      q_wdata;
    tlx_pkg::bundle_t      q_rdata;
    logic                  out_valid;
    tlx_pkg::res_t         out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= LEN_WIDTH'(tlx_pkg::CFG_RESET);
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    tlx_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .text_byte (text_byte),
        .max_len   (max_len_reg),
        .q_wdata   (q_wdata),
        .q_push    (q_push)
    );

    tlx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wdata),
        .q_full   (q_full),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rdata),
        .rd_en    (q_rd_en)
    );

    tlx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (q_rd_valid),
        .rd_data   (q_rdata),
        .rd_en     (q_rd_en),
        .pop       (pop),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign empty       = !out_valid;
    assign token_class = out_res.cls;
    assign out_char    = out_res.ch;
    assign char_valid  = out_res.valid;
    assign token_end   = out_res.tend;
    assign line_number = out_res.line;

    `TTL_ASSERT_NEVER(a_queue_overflow, clk, rst_n, q_push && q_full, "bundle queue overflow")
    `TTL_ASSERT_IMPLY(a_bundle_nonempty, clk, rst_n, q_push, q_wdata.count != 2'd0, "empty bundle queued")
    `TTL_ASSERT_IMPLY(a_closing_char, clk, rst_n, !empty && char_valid && token_end, token_class == tlx_pkg::CLS_OP, "stored char on non-operator close")
    `TTL_ASSERT_IMPLY(a_line_nonzero, clk, rst_n, !empty, line_number != '0, "line number zero")

endmodule

`default_nettype wire

[verif/text_token_lexer_tb.sv]
// ---------------------------------------------------------------------------
// text_token_lexer_tb
// Self-checking bench for the streaming tokenizer. A scoreboard object keeps
// its own copy of the lexer state and predicts the token characters of each
// accepted byte; every popped beat is compared field by field against the
// oldest prediction. Stimulus is a short directed text, then random token
// streams under several capacity settings, with random gaps on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_token_lexer_tb;

    import tlx_pkg::*;

    localparam int LW           = LEN_WIDTH_DEF;
    localparam int SETTLE       = 10;
    localparam int LONG_HOLD    = 60;
    localparam int PHASE_BEATS  = 56;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 60;

    typedef struct packed {
        logic       k;
        logic [7:0] b;
    } beat_t;

    // -----------------------------------------------------------------------
    // Token scoreboard: lexer state copy plus the queue of predicted beats
    // -----------------------------------------------------------------------
    class token_scoreboard;
        mode_t             mode;
        logic [LINE_W-1:0] line_cnt;
        logic [LW-1:0]     tok_len;
        logic [LW-1:0]     len_reg;
        bit                join_pend;
        bit                esc_pend;
        bit                slash_pend;
        int                made;
        int                results_seen;
        int                mismatches;
        res_t              expected_chars[$];

        function new();
            mode         = MODE_IDLE;
            line_cnt     = 1;
            tok_len      = '0;
            len_reg      = CFG_RESET;
            join_pend    = 1'b0;
            esc_pend     = 1'b0;
            slash_pend   = 1'b0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function void set_len(logic [LW-1:0] v);
            len_reg = v;
        endfunction

        function bit digit_ch(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit letter_ch(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit blank_ch(logic [7:0] b);
            return b == " " || b == "\t" || b == 8'h0D || b == 8'h00;
        endfunction

        function bit oper_ch(logic [7:0] b);
            bit hit;
            case (b)
                CH_AT, ",", "!", "&", "*", "$", ".", "=", ":",
                "[", "]", "(", ")", "{", "}", CH_BSLASH: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        endfunction

        function int unsigned room();
            return (len_reg > CAP_LIMIT) ? CAP_LIMIT : int'(len_reg);
        endfunction

        // At most three beats per byte; anything past that is dropped
        function void give(cls_t c, logic [7:0] ch, logic v, logic e);
            res_t r;
            if (made >= RES_MAX)
                return;
            r.cls   = c;
            r.ch    = ch;
            r.valid = v;
            r.tend  = e;
            r.line  = line_cnt;
            expected_chars.push_back(r);
            made++;
        endfunction

        function void line_step();
            if (line_cnt != LINE_MAX)
                line_cnt++;
        endfunction

        function void store(cls_t c, logic [7:0] b);
            if (tok_len + 32'd1 < room()) begin
                give(c, b, 1'b1, 1'b0);
                tok_len++;
            end
        endfunction

        function void from_idle(logic [7:0] b);
            mode = MODE_IDLE;
            if (slash_pend) begin
                slash_pend = 1'b0;
                if (b == CH_SLASH) begin
                    mode = MODE_COMMENT;
                    return;
                end
                give(CLS_ERR, CH_SLASH, 1'b0, 1'b1);
            end
            if (blank_ch(b) || b == CH_PLUS)
                return;
            if (b == CH_NL)
                line_step();
            else if (b == CH_SLASH)
                slash_pend = 1'b1;
            else if (oper_ch(b))
                give(CLS_OP, b, 1'b1, 1'b1);
            else if (b == CH_QUOTE) begin
                mode     = MODE_STR;
                tok_len  = '0;
                esc_pend = 1'b0;
            end else if (digit_ch(b) || b == CH_MINUS) begin
                mode    = MODE_INT;
                tok_len = '0;
                store(CLS_INT, b);
            end else if (letter_ch(b) || b == CH_UNDER) begin
                mode    = MODE_IDENT;
                tok_len = '0;
                store(CLS_IDENT, b);
            end else
                give(CLS_ERR, b, 1'b0, 1'b1);
        endfunction

        function void in_string(logic [7:0] b);
            if (b == CH_QUOTE) begin
                esc_pend  = 1'b0;
                join_pend = 1'b0;
                mode      = MODE_STR_AFTER;
            end else if (esc_pend) begin
                esc_pend = 1'b0;
                give(CLS_STR, (b == CH_N) ? CH_NL : b, 1'b1, 1'b0);
                tok_len++;
            end else if (b == CH_NL || tok_len + 32'd1 >= room()) begin
                give(CLS_STR_BAD, b, 1'b0, 1'b1);
                mode = MODE_DISCARD;
            end else if (b == CH_BSLASH)
                esc_pend = 1'b1;
            else begin
                give(CLS_STR, b, 1'b1, 1'b0);
                tok_len++;
            end
        endfunction

        // Closed string: wait for '+' and another quote, or close the token
        function void after_string(logic [7:0] b);
            if (slash_pend) begin
                if (b == CH_SLASH) begin
                    slash_pend = 1'b0;
                    mode       = MODE_COMMENT_AFTER;
                    return;
                end
                give(CLS_STR, 8'h00, 1'b0, 1'b1);
                join_pend = 1'b0;
                from_idle(b);
                return;
            end
            if (blank_ch(b))
                return;
            if (b == CH_PLUS)
                join_pend = 1'b1;
            else if (b == CH_NL)
                line_step();
            else if (b == CH_SLASH)
                slash_pend = 1'b1;
            else if (b == CH_QUOTE && join_pend) begin
                join_pend = 1'b0;
                esc_pend  = 1'b0;
                mode      = MODE_STR;
            end else begin
                give(CLS_STR, 8'h00, 1'b0, 1'b1);
                join_pend = 1'b0;
                from_idle(b);
            end
        endfunction

        function void close_input();
            case (mode)
                MODE_IDENT:     give(CLS_IDENT, 8'h00, 1'b0, 1'b1);
                MODE_INT:       give(CLS_INT, 8'h00, 1'b0, 1'b1);
                MODE_STR:       give(CLS_STR_BAD, 8'h00, 1'b0, 1'b1);
                MODE_STR_AFTER: give(CLS_STR, 8'h00, 1'b0, 1'b1);
                MODE_COMMENT:   line_step();
                MODE_COMMENT_AFTER:
                begin
                    line_step();
                    give(CLS_STR, 8'h00, 1'b0, 1'b1);
                end
                default: ;
            endcase
            if (slash_pend)
                give(CLS_ERR, CH_SLASH, 1'b0, 1'b1);
            give(CLS_END, 8'h00, 1'b0, 1'b1);
            mode       = MODE_IDLE;
            tok_len    = '0;
            join_pend  = 1'b0;
            esc_pend   = 1'b0;
            slash_pend = 1'b0;
        endfunction

        // Predict the beats caused by one accepted input
        function void lex_byte(logic k, logic [7:0] b);
            made = 0;
            if (k) begin
                close_input();
                return;
            end
            case (mode)
                MODE_IDENT:
                begin
                    if (letter_ch(b) || digit_ch(b) || b == CH_UNDER)
                        store(CLS_IDENT, b);
                    else begin
                        give(CLS_IDENT, 8'h00, 1'b0, 1'b1);
                        from_idle(b);
                    end
                end
                MODE_INT:
                begin
                    if (digit_ch(b))
                        store(CLS_INT, b);
                    else if (b == CH_MINUS || letter_ch(b) || b == CH_UNDER) begin
                        give(CLS_ERR, b, 1'b0, 1'b1);
                        mode = MODE_IDLE;
                    end else begin
                        give(CLS_INT, 8'h00, 1'b0, 1'b1);
                        from_idle(b);
                    end
                end
                MODE_STR:       in_string(b);
                MODE_STR_AFTER: after_string(b);
                MODE_DISCARD:
                begin
                    if (b == CH_QUOTE) begin
                        mode     = MODE_STR;
                        tok_len  = '0;
                        esc_pend = 1'b0;
                    end
                end
                MODE_COMMENT, MODE_COMMENT_AFTER:
                begin
                    if (b == CH_NL) begin
                        line_step();
                        mode = (mode == MODE_COMMENT) ? MODE_IDLE : MODE_STR_AFTER;
                    end
                end
                default: from_idle(b);
            endcase
        endfunction

        task report(string field, int got, int want);
            if (mismatches < PRINT_LIMIT)
                $display("t=%0t beat %0d: %s got %0h expected %0h",
                         $time, results_seen, field, got, want);
            mismatches++;
        endtask

        task check_result(logic [2:0] cls, logic [7:0] ch, logic v, logic e,
                          logic [LINE_W-1:0] ln);
            res_t w;
            if (expected_chars.size() == 0)
                report("unexpected beat, class", cls, 0);
            else begin
                w = expected_chars.pop_front();
                if (cls !== w.cls) report("token_class", cls, w.cls);
                if (ch !== w.ch)   report("out_char", ch, w.ch);
                if (v !== w.valid) report("char_valid", v, w.valid);
                if (e !== w.tend)  report("token_end", e, w.tend);
                if (ln !== w.line) report("line_number", ln, w.line);
            end
            results_seen++;
        endtask
    endclass

    // -----------------------------------------------------------------------
    // DUT and clock
    // -----------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              kind;
    logic [7:0]        text_byte;
    logic              empty;
    logic              pop;
    logic [2:0]        token_class;
    logic [7:0]        out_char;
    logic              char_valid;
    logic              token_end;
    logic [LINE_W-1:0] line_number;
    logic              cfg_we;
    logic [LW-1:0]     cfg_wdata;

    token_scoreboard   lex_sb;
    beat_t             text_stream[$];
    bit                hold_request = 1'b0;
    int                sink_stall_pct = 25;
    int                cycle_count = 0;
    int unsigned       phase_caps[8] = '{1024, 0, 1, 2, 3, 2047, 5, 256};

    text_token_lexer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .text_byte   (text_byte),
        .empty       (empty),
        .pop         (pop),
        .token_class (token_class),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .token_end   (token_end),
        .line_number (line_number),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Track every accepted beat on both sides and every register write
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                lex_sb.set_len(cfg_wdata);
            if (push && !full)
                lex_sb.lex_byte(kind, text_byte);
            if (pop && !empty)
                lex_sb.check_result(token_class, out_char, char_valid, token_end,
                                    line_number);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("text_token_lexer_tb NOT OK");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stall pattern helpers and stream builders
    // -----------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void put(logic k, logic [7:0] b);
        text_stream.push_back({k, b});
    endfunction

    function automatic logic [7:0] letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return letter();
        return (r < 9) ? digit() : CH_UNDER;
    endfunction

    // Opening quote and body; escapes, raw newlines and plain text
    function automatic void string_body(int unsigned span);
        int unsigned j;
        int r;
        logic [7:0] b;
        put(1'b0, CH_QUOTE);
        for (j = 0; j < span; j++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                put(1'b0, CH_BSLASH);
                put(1'b0, ($urandom_range(0, 1) == 0) ? CH_N : 8'($urandom_range(0, 255)));
            end else if (r < 16)
                put(1'b0, CH_NL);
            else begin
                b = $urandom_range(32, 126);
                put(1'b0, (b == CH_QUOTE) ? 8'("a") : b);
            end
        end
    endfunction

    function automatic void compose_text(int unsigned beats, int unsigned cap);
        int unsigned pick, span, j;
        int r;
        logic [7:0] b;
        while (text_stream.size() < beats) begin
            pick = $urandom_range(0, 99);
            if (cap <= 8)
                span = $urandom_range(0, cap + 2);
            else
                span = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 12 : 5);
            if (pick < 12) begin
                put(1'b0, ($urandom_range(0, 4) == 0) ? CH_UNDER : letter());
                for (j = 0; j < span; j++)
                    put(1'b0, word_char());
            end else if (pick < 22) begin
                if ($urandom_range(0, 2) == 0)
                    put(1'b0, CH_MINUS);
                for (j = 0; j <= span; j++)
                    put(1'b0, digit());
                if ($urandom_range(0, 3) == 0) begin
                    r = $urandom_range(0, 2);
                    put(1'b0, (r == 0) ? CH_MINUS : (r == 1) ? letter() : CH_UNDER);
                end
            end else if (pick < 40) begin
                string_body(span);
                if ($urandom_range(0, 9) != 0)
                    put(1'b0, CH_QUOTE);
                if ($urandom_range(0, 2) == 0) begin
                    if ($urandom_range(0, 1) == 0)
                        put(1'b0, " ");
                    put(1'b0, CH_PLUS);
                    if ($urandom_range(0, 1) == 0)
                        put(1'b0, ($urandom_range(0, 1) == 0) ? CH_NL : 8'("\t"));
                    string_body($urandom_range(0, 3));
                    put(1'b0, CH_QUOTE);
                end
            end else if (pick < 50) begin
                case ($urandom_range(0, 15))
                    0:  b = CH_AT;
                    1:  b = ",";
                    2:  b = "!";
                    3:  b = "&";
                    4:  b = "*";
                    5:  b = "$";
                    6:  b = ".";
                    7:  b = "=";
                    8:  b = ":";
                    9:  b = "[";
                    10: b = "]";
                    11: b = "(";
                    12: b = ")";
                    13: b = "{";
                    14: b = "}";
                    default: b = CH_BSLASH;
                endcase
                put(1'b0, b);
            end else if (pick < 58) begin
                put(1'b0, CH_SLASH);
                put(1'b0, CH_SLASH);
                for (j = 0; j < span; j++) begin
                    b = $urandom_range(0, 255);
                    put(1'b0, (b == CH_NL) ? 8'(" ") : b);
                end
                if ($urandom_range(0, 6) != 0)
                    put(1'b0, CH_NL);
            end else if (pick < 63)
                put(1'b0, CH_SLASH);
            else if (pick < 80) begin
                case ($urandom_range(0, 5))
                    0: b = " ";
                    1: b = "\t";
                    2: b = 8'h0D;
                    3: b = 8'h00;
                    4: b = CH_PLUS;
                    default: b = CH_NL;
                endcase
                put(1'b0, b);
            end else if (pick < 85)
                put(1'b1, 8'($urandom_range(0, 255)));
            else if (pick < 92)
                put(1'b0, 8'($urandom_range(128, 255)));
            else
                put(1'b0, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
                put(1'b0, ($urandom_range(0, 3) == 0) ? CH_NL : 8'(" "));
        end
    endfunction

    // -----------------------------------------------------------------------
    // Driver tasks
    // -----------------------------------------------------------------------
    // Offer one beat and hold it while full reads high after each clock edge; push is left high
    task automatic send_beat(logic k, logic [7:0] b);
        push      <= 1'b1;
        kind      <= k;
        text_byte <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic play_stream(bit with_gaps);
        beat_t bt;
        int gap;
        while (text_stream.size() > 0) begin
            bt = text_stream.pop_front();
            send_beat(bt.k, bt.b);
            gap = with_gaps ? gap_len() : 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (lex_sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_len(logic [LW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result sink: random pop stalls, plus one long hold on request
    // -----------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int hold_count;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                hold_count = 0;
                while (hold_count < LONG_HOLD) begin
                    @(posedge clk);
                    hold_count++;
                end
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 99) < sink_stall_pct)
                    stall_left = gap_len();
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        string directed;
        int i;
        int unsigned cap;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        kind      <= 1'b0;
        text_byte <= 8'h00;
        pop       <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        lex_sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Operators, identifier, integer error, escapes, dropped backslash
        // before a quote, string join, comment after a string, lone slash
        // closing a string, unknown high bytes, end of input
        directed = "@\\_Z9 -7q\"\\n\\\"+\"x\"//\n/";
        for (i = 0; i < directed.len(); i++)
            put(1'b0, directed[i]);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h80);
        put(1'b1, 8'h00);
        play_stream(1'b1);

        for (i = 0; i < 8; i++) begin
            wait_drained();
            write_len(phase_caps[i]);
            cap = (phase_caps[i] > CAP_LIMIT) ? CAP_LIMIT : phase_caps[i];
            sink_stall_pct = (i == 5) ? 0 : 25;
            // first phase: back-to-back beats against a stalled sink
            if (i == 0)
                hold_request = 1'b1;
            compose_text(PHASE_BEATS, cap);
            play_stream(i != 0);
        end
        wait_drained();

        if (lex_sb.mismatches == 0)
            $display("text_token_lexer_tb OK");
        else
            $display("text_token_lexer_tb NOT OK");
        $finish;
    end

endmodule

[text_token_lexer.f]
+incdir+rtl
rtl/tlx_pkg.sv
rtl/tlx_front.sv
rtl/tlx_queue.sv
rtl/tlx_back.sv
rtl/text_token_lexer.sv
verif/text_token_lexer_tb.sv
